[hdl/sediment_fraction_eroder_assert.svh]
// Assertion macros for the sediment fraction eroder
`ifndef SEDIMENT_FRACTION_ERODER_ASSERT_SVH
`define SEDIMENT_FRACTION_ERODER_ASSERT_SVH
// Check that a condition implies another on the same edge
`define SFE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Check that a condition implies another on the next edge
`define SFE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[hdl/sfe_pkg.sv]
// Types, codes and constants shared by the eroder files
package sfe_pkg;
    localparam int NFRAC = 3;
    localparam int THICK_W = 32;
    localparam int WEIGHT_W = 16;
    localparam int PROD_W = THICK_W + WEIGHT_W;
    localparam int TOTW_W = WEIGHT_W + 2;

    typedef enum logic [2:0] {
        ACT_FLOW      = 3'd0,
        ACT_SPLASH    = 3'd1,
        ACT_SLUMP     = 3'd2,
        ACT_DEP_MAIN  = 3'd3,
        ACT_DEP_TEMP  = 3'd4,
        ACT_LOAD_MAIN = 3'd5,
        ACT_LOAD_TEMP = 3'd6,
        ACT_NONE      = 3'd7
    } action_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_ZEROW = 2'd2,
        ST_SAT   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CFG_FLOW   = 2'd0,
        CFG_SPLASH = 2'd1,
        CFG_SLUMP  = 2'd2,
        CFG_ZTOL   = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_DIV,
        FSM_OUT
    } fsm_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] erode_amount;
        logic [31:0] clay_amount;
        logic [31:0] silt_amount;
        logic [31:0] sand_amount;
    } in_item_t;

    typedef struct packed {
        logic [31:0] clay_removed;
        logic [31:0] silt_removed;
        logic [31:0] sand_removed;
        logic [31:0] clay_left;
        logic [31:0] silt_left;
        logic [31:0] sand_left;
        logic [33:0] layer_total;
        logic [1:0]  status;
    } out_item_t;

    // lane control from the sequencer
    typedef struct packed {
        logic start;
        logic [PROD_W-1:0] dividend;
        logic [TOTW_W-1:0] divisor;
    } lane_cmd_t;
endpackage

[hdl/sediment_fraction_eroder.sv]
// Top level of the sediment fraction eroder
// Keeps one soil layer's clay, silt and sand thicknesses in a main and a
// temporary set, and erodes, deposits or loads them one item at a time.
// Channels: in (valid/ready, in_item_t), out (valid/ready, out_item_t) and
// a configuration write channel cfg (index, data) for the weight registers
// and the empty-layer tolerance. Write configuration only while idle.
// Sequence: an erosion item that reaches the dividers goes from acceptance
// through a setup, 48 divider steps, a merge and an output step to the result
// beat; other items go straight to the output step. The three fraction lanes
// divide side by side, each one quotient bit a cycle.
// One item is in work at a time; the next is accepted once the result beat
// has been registered in the output stage, so a stalled receiver holds the
// result and blocks only a second item.
// Reset clears both thickness sets, the configuration registers and the lane
// counters to zero, sets the sequencer idle and empties the output stage.
module sediment_fraction_eroder (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sfe_pkg::in_item_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output sfe_pkg::out_item_t out_data,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [47:0] cfg_data
);
    import sfe_pkg::*;
    `include "sediment_fraction_eroder_assert.svh"

    logic [47:0] wflow_reg, wsplash_reg, wslump_reg;
    logic [15:0] ztol_reg;
    logic [THICK_W-1:0] main_reg [NFRAC];
    logic [THICK_W-1:0] temp_reg [NFRAC];
    logic [THICK_W-1:0] main_next [NFRAC];
    logic [THICK_W-1:0] temp_next [NFRAC];
    fsm_t state_reg, state_next;
    logic use_temp_reg, use_temp_next;
    logic [NFRAC-1:0] pres_reg, pres_next;
    logic [THICK_W-1:0] rem_reg [NFRAC];
    logic [THICK_W-1:0] rem_next [NFRAC];
    logic [1:0] status_reg, status_next;
    logic ovalid_reg, ovalid_next;
    out_item_t odata_reg, odata_next;
    lane_cmd_t cmd [NFRAC];
    logic [NFRAC-1:0] busy;
    logic [THICK_W-1:0] share [NFRAC];
    logic [47:0] wsel;
    logic [TOTW_W-1:0] totw;
    logic [33:0] mtot;
    logic [32:0] dsum;
    logic in_fire;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == FSM_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wflow_reg <= '0;
            wsplash_reg <= '0;
            wslump_reg <= '0;
            ztol_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_FLOW:   wflow_reg <= cfg_data;
                CFG_SPLASH: wsplash_reg <= cfg_data;
                CFG_SLUMP:  wslump_reg <= cfg_data;
                CFG_ZTOL:   ztol_reg <= cfg_data[15:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (in_data.action)
            ACT_FLOW:   wsel = wflow_reg;
            ACT_SPLASH: wsel = wsplash_reg;
            default:    wsel = wslump_reg;
        endcase
        mtot = 34'(main_reg[0]) + 34'(main_reg[1]) + 34'(main_reg[2]);
        totw = '0;
        for (int f = 0; f < NFRAC; f++)
            if (main_reg[f] != '0)
                totw = totw + TOTW_W'(wsel[32-16*f +: 16]);
    end

    for (genvar g = 0; g < NFRAC; g++)
    begin : g_lane
        assign cmd[g].start = in_fire && (in_data.action == ACT_FLOW
            || in_data.action == ACT_SPLASH || in_data.action == ACT_SLUMP)
            && mtot > 34'(ztol_reg) && totw != '0;
        assign cmd[g].dividend = PROD_W'(wsel[32-16*g +: 16]) * PROD_W'(in_data.erode_amount);
        assign cmd[g].divisor = totw;
        sfe_lane u_lane (
            .clk(clk), .rst_n(rst_n), .cmd(cmd[g]), .busy(busy[g]), .share(share[g])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        use_temp_next = use_temp_reg;
        pres_next = pres_reg;
        status_next = status_reg;
        ovalid_next = ovalid_reg;
        odata_next = odata_reg;
        dsum = '0;
        for (int f = 0; f < NFRAC; f++)
        begin
            main_next[f] = main_reg[f];
            temp_next[f] = temp_reg[f];
            rem_next[f] = rem_reg[f];
        end
        if (ovalid_reg && out_ready)
            ovalid_next = 1'b0;
        case (state_reg)
            FSM_IDLE:
            begin
                if (in_fire)
                begin
                    status_next = ST_DONE;
                    for (int f = 0; f < NFRAC; f++)
                        rem_next[f] = '0;
                    state_next = FSM_OUT;
                    case (in_data.action)
                        ACT_FLOW, ACT_SPLASH, ACT_SLUMP:
                        begin
                            use_temp_next = (in_data.action == ACT_FLOW);
                            for (int f = 0; f < NFRAC; f++)
                                pres_next[f] = (main_reg[f] != '0);
                            if (mtot <= 34'(ztol_reg))
                                status_next = ST_EMPTY;
                            else if (totw == '0)
                                status_next = ST_ZEROW;
                            else
                                state_next = FSM_DIV;
                        end
                        ACT_DEP_MAIN, ACT_DEP_TEMP:
                        begin
                            for (int f = 0; f < NFRAC; f++)
                            begin
                                case (f)
                                    0: dsum = 33'(in_data.clay_amount);
                                    1: dsum = 33'(in_data.silt_amount);
                                    default: dsum = 33'(in_data.sand_amount);
                                endcase
                                if (in_data.action == ACT_DEP_MAIN)
                                    dsum = dsum + 33'(main_reg[f]);
                                else
                                    dsum = dsum + 33'(temp_reg[f]);
                                if (dsum[32])
                                begin
                                    dsum = {1'b0, {32{1'b1}}};
                                    status_next = ST_SAT;
                                end
                                if (in_data.action == ACT_DEP_MAIN)
                                    main_next[f] = dsum[31:0];
                                else
                                    temp_next[f] = dsum[31:0];
                            end
                        end
                        ACT_LOAD_MAIN:
                        begin
                            main_next[0] = in_data.clay_amount;
                            main_next[1] = in_data.silt_amount;
                            main_next[2] = in_data.sand_amount;
                        end
                        ACT_LOAD_TEMP:
                        begin
                            temp_next[0] = in_data.clay_amount;
                            temp_next[1] = in_data.silt_amount;
                            temp_next[2] = in_data.sand_amount;
                        end
                        default: ;
                    endcase
                end
            end
            FSM_DIV:
            begin
                // merge: clamp each lane's share and lower the chosen set
                if (busy == '0)
                begin
                    for (int f = 0; f < NFRAC; f++)
                        if (pres_reg[f])
                        begin
                            if (use_temp_reg)
                            begin
                                rem_next[f] = (share[f] < temp_reg[f]) ? share[f] : temp_reg[f];
                                temp_next[f] = temp_reg[f] - rem_next[f];
                            end
                            else
                            begin
                                rem_next[f] = (share[f] < main_reg[f]) ? share[f] : main_reg[f];
                                main_next[f] = main_reg[f] - rem_next[f];
                            end
                        end
                    state_next = FSM_OUT;
                end
            end
            FSM_OUT:
            begin
                // hold until the output stage is free
                if (!ovalid_reg || out_ready)
                begin
                    odata_next.clay_removed = rem_reg[0];
                    odata_next.silt_removed = rem_reg[1];
                    odata_next.sand_removed = rem_reg[2];
                    odata_next.clay_left = main_reg[0];
                    odata_next.silt_left = main_reg[1];
                    odata_next.sand_left = main_reg[2];
                    odata_next.layer_total = mtot;
                    odata_next.status = status_reg;
                    ovalid_next = 1'b1;
                    state_next = FSM_IDLE;
                end
            end
            default: state_next = FSM_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_IDLE;
            ovalid_reg <= 1'b0;
            for (int f = 0; f < NFRAC; f++)
            begin
                main_reg[f] <= '0;
                temp_reg[f] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            ovalid_reg <= ovalid_next;
            for (int f = 0; f < NFRAC; f++)
            begin
                main_reg[f] <= main_next[f];
                temp_reg[f] <= temp_next[f];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        use_temp_reg <= use_temp_next;
        pres_reg <= pres_next;
        status_reg <= status_next;
        odata_reg <= odata_next;
        for (int f = 0; f < NFRAC; f++)
            rem_reg[f] <= rem_next[f];
    end

    `SFE_ASSERT_IMP(a_no_accept_busy, state_reg != FSM_IDLE, !in_ready)
    `SFE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
    `SFE_ASSERT_IMP(a_lanes_together, 1'b1, busy == '0 || busy == '1)
endmodule

[hdl/sfe_lane.sv]
// One lane: serial restoring divider for a fraction's share
module sfe_lane (
    input  logic clk,
    input  logic rst_n,
    input  sfe_pkg::lane_cmd_t cmd,
    output logic busy,
    output logic [sfe_pkg::THICK_W-1:0] share
);
    import sfe_pkg::*;
    localparam int CNT_W = $clog2(PROD_W + 1);

    logic [PROD_W-1:0] quo_reg, quo_next;
    logic [TOTW_W-1:0] rem_reg, rem_next;
    logic [TOTW_W-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [TOTW_W:0]   trial;

    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        cnt_next = cnt_reg;
        trial = {rem_reg, quo_reg[PROD_W-1]};
        if (cmd.start)
        begin
            quo_next = cmd.dividend;
            rem_next = '0;
            dsr_next = cmd.divisor;
            cnt_next = CNT_W'(PROD_W);
        end
        else if (cnt_reg != '0)
        begin
            // shift one dividend bit in, subtract when it fits
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = TOTW_W'(trial - {1'b0, dsr_reg});
                quo_next = {quo_reg[PROD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[TOTW_W-1:0];
                quo_next = {quo_reg[PROD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy  = (cnt_reg != '0);
    assign share = quo_reg[THICK_W-1:0];
endmodule
